// ===== design/bmp2fb_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp2fb_pkg
// Shared types and constants for the 24-bit bmp to frame buffer blitter.
// ----------------------------------------------------------------------------
package bmp2fb_pkg;

  localparam int DEF_SCREEN_WIDTH  = 800;
  localparam int DEF_SCREEN_HEIGHT = 480;
  localparam int DEF_MAX_IMAGE_DIM = 2048;
  localparam int DEF_QUEUE_DEPTH   = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int POS_X_W    = 10;
  localparam int POS_Y_W    = 9;
  localparam int BYTE_W     = 8;
  localparam int PIXEL_W    = 24;
  localparam int FB_ADDR_W  = 19;

  // screen coordinates held in the queue, wide enough for the largest screen
  localparam int SCR_COORD_W = 12;

  localparam logic [CFG_DATA_W-1:0] RST_IMG_WIDTH  = CFG_DATA_W'(800);
  localparam logic [CFG_DATA_W-1:0] RST_IMG_HEIGHT = CFG_DATA_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_WIDTH  = 2'd0,
    CFG_IMG_HEIGHT = 2'd1,
    CFG_POS_X      = 2'd2,
    CFG_POS_Y      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [SCR_COORD_W-1:0] col;
    logic [SCR_COORD_W-1:0] row;
    logic [PIXEL_W-1:0]     pixel;
  } fb_pixel_t;

  typedef struct packed {
    logic      push;
    fb_pixel_t pix;
  } q_wr_t;

  typedef struct packed {
    logic      valid;
    fb_pixel_t pix;
  } q_rd_t;

endpackage

// ===== design/bmp2fb_front.sv =====
// ----------------------------------------------------------------------------
// bmp2fb_front
// Byte intake: configuration registers, byte phase, padding skip, column and
// row counters, on-screen test and queue push of finished pixels.
// ----------------------------------------------------------------------------
module bmp2fb_front
  import bmp2fb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic                  q_full,
  output q_wr_t                 q_wr
);

  localparam int DIM_W   = $clog2(MAX_IMAGE_DIM);
  localparam int DIM1_W  = DIM_W + 1;
  localparam int CLAMP_W = CFG_DATA_W + 1;
  localparam int SUM_W   = (DIM1_W > 13 ? DIM1_W : 13) + 1;

  logic [CFG_DATA_W-1:0] img_width_r;
  logic [CFG_DATA_W-1:0] img_height_r;
  logic [POS_X_W-1:0]    pos_x_r;
  logic [POS_Y_W-1:0]    pos_y_r;

  phase_t                phase_r, phase_nxt;
  logic [15:0]           held_bg_r, held_bg_nxt;
  logic [DIM_W-1:0]      col_cnt_r, col_cnt_nxt;
  logic [DIM_W-1:0]      rfb_r, rfb_nxt;
  logic [1:0]            pad_r, pad_nxt;

  logic                  in_acc;
  logic                  is_red;
  logic [DIM1_W-1:0]     w_cl, h_cl;
  logic [DIM1_W-1:0]     col_inc, rfb_inc, row_off;
  logic [DIM_W-1:0]      row_adv;
  logic                  row_in;
  logic [SUM_W-1:0]      csum, rsum;
  logic                  on_screen;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= RST_IMG_WIDTH;
      img_height_r <= RST_IMG_HEIGHT;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMG_WIDTH:  img_width_r  <= cfg_data;
        CFG_IMG_HEIGHT: img_height_r <= cfg_data;
        CFG_POS_X:      pos_x_r      <= cfg_data[POS_X_W-1:0];
        CFG_POS_Y:      pos_y_r      <= cfg_data[POS_Y_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  always_comb begin
    if (img_width_r == '0) begin
      w_cl = DIM1_W'(1);
    end else if ({1'b0, img_width_r} > CLAMP_W'(MAX_IMAGE_DIM)) begin
      w_cl = DIM1_W'(MAX_IMAGE_DIM);
    end else begin
      w_cl = DIM1_W'(img_width_r);
    end
    if (img_height_r == '0) begin
      h_cl = DIM1_W'(1);
    end else if ({1'b0, img_height_r} > CLAMP_W'(MAX_IMAGE_DIM)) begin
      h_cl = DIM1_W'(MAX_IMAGE_DIM);
    end else begin
      h_cl = DIM1_W'(img_height_r);
    end
  end

  assign is_red   = (pad_r == '0) && (phase_r == PH_RED);
  assign in_ready = !(is_red && q_full);
  assign in_acc   = in_valid && in_ready;

  // byte phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc && pad_r == '0) begin
      unique case (phase_r)
        PH_BLUE:  phase_nxt = PH_GREEN;
        PH_GREEN: phase_nxt = PH_RED;
        PH_RED:   phase_nxt = PH_BLUE;
        default:  phase_nxt = PH_BLUE;
      endcase
    end
  end

  // screen position of the pixel in flight
  always_comb begin
    col_inc   = {1'b0, col_cnt_r} + DIM1_W'(1);
    rfb_inc   = {1'b0, rfb_r} + DIM1_W'(1);
    row_adv   = (rfb_inc >= h_cl) ? '0 : rfb_inc[DIM_W-1:0];
    row_in    = {1'b0, rfb_r} < h_cl;
    row_off   = h_cl - DIM1_W'(1) - {1'b0, rfb_r};
    csum      = SUM_W'(pos_x_r) + SUM_W'(col_cnt_r);
    rsum      = SUM_W'(pos_y_r) + SUM_W'(row_off);
    on_screen = row_in && (csum < SUM_W'(SCREEN_WIDTH)) && (rsum < SUM_W'(SCREEN_HEIGHT));
  end

  always_comb begin
    q_wr.push      = in_acc && is_red && on_screen;
    q_wr.pix.col   = SCR_COORD_W'(csum);
    q_wr.pix.row   = SCR_COORD_W'(rsum);
    q_wr.pix.pixel = {in_data_byte, held_bg_r};
  end

  // counters and held bytes
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    rfb_nxt     = rfb_r;
    pad_nxt     = pad_r;
    held_bg_nxt = held_bg_r;
    if (in_acc) begin
      priority if (pad_r != '0) begin
        pad_nxt = pad_r - 2'd1;
        if (pad_r == 2'd1) rfb_nxt = row_adv;
      end else begin
        unique case (phase_r)
          PH_BLUE:  held_bg_nxt = {8'h00, in_data_byte};
          PH_GREEN: held_bg_nxt = {in_data_byte, held_bg_r[7:0]};
          PH_RED: begin
            if (col_inc >= w_cl) begin
              col_cnt_nxt = '0;
              pad_nxt     = w_cl[1:0];
              if (w_cl[1:0] == 2'b00) rfb_nxt = row_adv;
            end else begin
              col_cnt_nxt = col_inc[DIM_W-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_BLUE;
      col_cnt_r <= '0;
      rfb_r     <= '0;
      pad_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      col_cnt_r <= col_cnt_nxt;
      rfb_r     <= rfb_nxt;
      pad_r     <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_bg_r <= held_bg_nxt;
  end

endmodule

// ===== design/bmp2fb_queue.sv =====
// ----------------------------------------------------------------------------
// bmp2fb_queue
// Short pixel queue between intake and address stage.
// ----------------------------------------------------------------------------
module bmp2fb_queue
  import bmp2fb_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  output q_rd_t q_rd,
  input  logic  q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fb_pixel_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full     = (cnt_r == CNT_W'(DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.pix   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    priority if (q_wr.push && !q_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (q_pop && !q_wr.push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) mem[wr_ptr_r] <= q_wr.pix;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && q_full))
    else $error("pixel pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && !q_rd.valid))
    else $error("pixel popped from empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count past depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.push && !q_pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count missed a push");

endmodule

// ===== design/bmp2fb_back.sv =====
// ----------------------------------------------------------------------------
// bmp2fb_back
// Address stage: frame buffer word index from screen row and column, held in
// the output register until taken.
// ----------------------------------------------------------------------------
module bmp2fb_back
  import bmp2fb_pkg::*;
#(
  parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  q_rd_t                q_rd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FB_ADDR_W-1:0] out_fb_address,
  output logic [PIXEL_W-1:0]   out_pixel_word
);

  localparam int SW_W    = $clog2(SCREEN_WIDTH + 1);
  localparam int CALC_W  = SCR_COORD_W + SW_W + 1;
  localparam int PROD_W  = (CALC_W > FB_ADDR_W) ? CALC_W : FB_ADDR_W;

  logic                 out_valid_r, out_valid_nxt;
  logic [FB_ADDR_W-1:0] fb_address_r;
  logic [PIXEL_W-1:0]   pixel_word_r;
  logic [PROD_W-1:0]    addr_full;

  assign q_pop     = q_rd.valid && (!out_valid_r || out_ready);
  assign addr_full = PROD_W'(q_rd.pix.row) * PROD_W'(SCREEN_WIDTH) + PROD_W'(q_rd.pix.col);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      fb_address_r <= addr_full[FB_ADDR_W-1:0];
      pixel_word_r <= q_rd.pix.pixel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fb_address = fb_address_r;
  assign out_pixel_word = pixel_word_r;

endmodule

// ===== design/bmp24_to_framebuffer_blit.sv =====
// ----------------------------------------------------------------------------
// bmp24_to_framebuffer_blit
// 24-bit bottom-up bmp pixel bytes in, frame buffer writes out: bgr bytes
// packed to 0xRRGGBB, row padding skipped, rows flipped and placed at
// (pos_x, pos_y), off-screen pixels dropped.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_data_byte
//   out      out_valid / out_ready  out_fb_address, out_pixel_word
//   cfg      cfg_wr_en              cfg_index, cfg_data
//
// one byte per cycle while in_ready; pixels pass the queue, then the output register
// in_ready drops only while a red byte waits on a full pixel queue
// the output register and the queue let the byte side run while out stalls
// reset is synchronous, active low, and needs a single cycle
// ----------------------------------------------------------------------------
module bmp24_to_framebuffer_blit
  import bmp2fb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM,
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FB_ADDR_W-1:0]  out_fb_address,
  output logic [PIXEL_W-1:0]    out_pixel_word
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  bmp2fb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_idx_t'(cfg_index)),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_wr         (q_wr)
  );

  bmp2fb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  bmp2fb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rd           (q_rd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_fb_address (out_fb_address),
    .out_pixel_word (out_pixel_word)
  );

endmodule

// ===== sim/bmp24_to_framebuffer_blit_tb.sv =====
// ----------------------------------------------------------------------------
// bmp24_to_framebuffer_blit_tb
// Self-checking bench for the bmp pixel stream blitter. Directed tests cover
// the register reset values, registers changed mid-image, clamping of zero and
// oversized dimensions, and clipping at the screen edges. A long output stall
// fills the pixel queue so the input side backs up. Random images of small
// size and random placement follow, some cut short and resynchronized under a
// new setting. Every frame buffer write is predicted per accepted byte and
// compared in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bmp24_to_framebuffer_blit_tb;
  import bmp2fb_pkg::*;

  localparam int ITEMS_TARGET = 1950;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [FB_ADDR_W-1:0] addr;
    logic [PIXEL_W-1:0]   pixel;
  } fb_write_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_data_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [FB_ADDR_W-1:0]  out_fb_address;
  logic [PIXEL_W-1:0]    out_pixel_word;

  // predictor copy of registers and counters
  logic [11:0] img_w;
  logic [11:0] img_h;
  logic [9:0]  org_x;
  logic [8:0]  org_y;
  phase_t      phase;
  logic [15:0] held_bg;
  logic [10:0] col_cnt;
  logic [10:0] row_up;
  logic [1:0]  pad_left;

  fb_write_t pending_fb_writes[$];
  int  fault_count;
  int  bytes_sent;
  int  in_idle_pct;
  int  out_idle_pct;
  bit  hold_out_req;
  int  quiet_cycles;

  bmp24_to_framebuffer_blit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_fb_address (out_fb_address),
    .out_pixel_word (out_pixel_word)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int clamp_dim(input logic [11:0] v);
    if (v == 12'd0) return 1;
    if (int'(v) > DEF_MAX_IMAGE_DIM) return DEF_MAX_IMAGE_DIM;
    return int'(v);
  endfunction

  function automatic void clear_blit_state();
    img_w    = RST_IMG_WIDTH;
    img_h    = RST_IMG_HEIGHT;
    org_x    = '0;
    org_y    = '0;
    phase    = PH_BLUE;
    held_bg  = '0;
    col_cnt  = '0;
    row_up   = '0;
    pad_left = '0;
  endfunction

  function automatic void advance_row(input int h);
    int nxt;
    nxt = int'(row_up) + 1;
    row_up = (nxt >= h) ? 11'd0 : 11'(nxt);
  endfunction

  function automatic void blit_byte(input logic [BYTE_W-1:0] b);
    int w, h, col, row;
    fb_write_t wr;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    if (pad_left != 2'd0) begin
      pad_left = pad_left - 2'd1;
      if (pad_left == 2'd0) advance_row(h);
      return;
    end
    case (phase)
      PH_BLUE: begin
        held_bg = {8'h00, b};
        phase = PH_GREEN;
      end
      PH_GREEN: begin
        held_bg[15:8] = b;
        phase = PH_RED;
      end
      default: begin
        phase = PH_BLUE;
        if (int'(row_up) < h) begin
          col = int'(org_x) + int'(col_cnt);
          row = int'(org_y) + h - 1 - int'(row_up);
          if (col < DEF_SCREEN_WIDTH && row < DEF_SCREEN_HEIGHT) begin
            wr.addr  = FB_ADDR_W'(row * DEF_SCREEN_WIDTH + col);
            wr.pixel = {b, held_bg};
            pending_fb_writes.push_back(wr);
          end
        end
        if (int'(col_cnt) + 1 >= w) begin
          col_cnt = '0;
          pad_left = 2'(w & 3);
          if (pad_left == 2'd0) advance_row(h);
        end else begin
          col_cnt = col_cnt + 11'd1;
        end
      end
    endcase
  endfunction

  function automatic bit at_image_start();
    return phase == PH_BLUE && col_cnt == '0 && row_up == '0 && pad_left == '0;
  endfunction

  function automatic int image_len(input int w, input int h);
    int cw;
    cw = clamp_dim(12'(w));
    return clamp_dim(12'(h)) * (3 * cw + (cw & 3));
  endfunction

  function automatic int idle_len();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = ($urandom_range(99) < in_idle_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    blit_byte(b);
    bytes_sent++;
  endtask

  task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red);
    send_byte(blue);
    send_byte(green);
    send_byte(red);
  endtask

  task automatic send_random_bytes(input int n);
    repeat (n) send_byte(BYTE_W'($urandom_range(255)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_fb_writes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(input int w, input int h, input int x, input int y);
    cfg_idx_t sel[4];
    int vals[4];
    wait_idle();
    sel[0] = CFG_IMG_WIDTH;
    sel[1] = CFG_IMG_HEIGHT;
    sel[2] = CFG_POS_X;
    sel[3] = CFG_POS_Y;
    vals[0] = w;
    vals[1] = h;
    vals[2] = x;
    vals[3] = y;
    cfg_wr_en <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= sel[i];
      cfg_data <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      case (sel[i])
        CFG_IMG_WIDTH:  img_w = 12'(vals[i]);
        CFG_IMG_HEIGHT: img_h = 12'(vals[i]);
        CFG_POS_X:      org_x = 10'(vals[i]);
        default:        org_y = 9'(vals[i]);
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int pick_small_dim(input int top);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 0;
    if (r < 88) return $urandom_range(1, 6);
    return $urandom_range(7, top);
  endfunction

  function automatic int pick_big_dim();
    case ($urandom_range(3))
      0: return 4095;
      1: return DEF_MAX_IMAGE_DIM;
      2: return DEF_MAX_IMAGE_DIM + 1;
      default: return $urandom_range(DEF_MAX_IMAGE_DIM + 2, 4094);
    endcase
  endfunction

  function automatic int pick_pos_x();
    return ($urandom_range(99) < 40) ? $urandom_range(780, DEF_SCREEN_WIDTH - 1)
                                     : $urandom_range(0, DEF_SCREEN_WIDTH - 1);
  endfunction

  function automatic int pick_pos_y();
    return ($urandom_range(99) < 40) ? $urandom_range(470, DEF_SCREEN_HEIGHT - 1)
                                     : $urandom_range(0, DEF_SCREEN_HEIGHT - 1);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  // out side: random stalls, long hold on request, in-order check
  initial begin : result_side
    int stall;
    fb_write_t exp_wr;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_fb_writes.size() == 0) begin
          note_fault($sformatf("unexpected write: addr %0d pixel %06h",
                               out_fb_address, out_pixel_word));
        end else begin
          exp_wr = pending_fb_writes.pop_front();
          if (out_fb_address !== exp_wr.addr || out_pixel_word !== exp_wr.pixel)
            note_fault($sformatf(
              "mismatch: expected addr %0d pixel %06h, got addr %0d pixel %06h",
              exp_wr.addr, exp_wr.pixel, out_fb_address, out_pixel_word));
        end
      end
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < out_idle_pct) begin
        stall = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_reset_values();
    send_pixel(8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_midimage_reconfig();
    program_regs(1, 2, 0, 0);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_random_bytes(1);
    program_regs(1, 1, 0, 0);
    send_pixel(8'h5a, 8'ha5, 8'h3c);
    send_random_bytes(1);
  endtask

  task automatic test_dim_clamp();
    program_regs(0, 0, DEF_SCREEN_WIDTH - 1, DEF_SCREEN_HEIGHT - 1);
    send_pixel(8'h01, 8'h80, 8'hfe);
    send_random_bytes(1);
    program_regs(4095, 4095, 0, 0);
    send_pixel(8'h7f, 8'h00, 8'hff);
  endtask

  task automatic test_off_screen_clip();
    program_regs(2, 1, DEF_SCREEN_WIDTH - 1, 10);
    send_random_bytes(3 + 2 + 6 + 2);
  endtask

  task automatic test_output_backpressure();
    program_regs(8, 4, 100, 100);
    in_idle_pct = 0;
    hold_out_req = 1'b1;
    send_random_bytes(image_len(8, 4));
  endtask

  task automatic test_random_images();
    int w, h;
    while (bytes_sent < ITEMS_TARGET) begin
      in_idle_pct = pick_idle_pct();
      out_idle_pct = pick_idle_pct();
      if ($urandom_range(99) < 85) begin
        w = pick_small_dim(24);
        h = pick_small_dim(8);
        program_regs(w, h, pick_pos_x(), pick_pos_y());
        send_random_bytes(image_len(w, h));
      end else begin
        w = $urandom_range(1) ? pick_big_dim() : pick_small_dim(24);
        h = $urandom_range(1) ? pick_big_dim() : pick_small_dim(8);
        program_regs(w, h, pick_pos_x(), pick_pos_y());
        send_random_bytes($urandom_range(1, 60));
        program_regs(pick_small_dim(24), pick_small_dim(8), pick_pos_x(), pick_pos_y());
        while (!at_image_start()) send_byte(BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    fault_count = 0;
    bytes_sent = 0;
    quiet_cycles = 0;
    hold_out_req = 1'b0;
    in_idle_pct = 10;
    out_idle_pct = 10;
    clear_blit_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_midimage_reconfig();
    test_dim_clamp();
    test_off_screen_clip();
    test_output_backpressure();
    test_random_images();

    wait_idle();
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== bmp24_to_framebuffer_blit.f =====
design/bmp2fb_pkg.sv
design/bmp2fb_front.sv
design/bmp2fb_queue.sv
design/bmp2fb_back.sv
design/bmp24_to_framebuffer_blit.sv
sim/bmp24_to_framebuffer_blit_tb.sv
